FILE: src/mpdr_pkg.sv
// ----------------------------------------------------------------------------
// mpdr_pkg
// Shared widths, reset values and register indexes of the mono packer with
// dirty-row tracking.
// ----------------------------------------------------------------------------
package mpdr_pkg;

  localparam int MaxWidthDef  = 512;
  localparam int MaxHeightDef = 256;

  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 10;
  localparam int WidthRegW  = 10;
  localparam int HeightRegW = 9;
  localparam int PixelW     = 16;
  localparam int ByteW      = 8;
  localparam int ByteColW   = 6;
  localparam int RowIdxW    = 8;
  localparam int CountW     = 9;

  localparam logic [WidthRegW-1:0]  WidthReset  = 10'd400;
  localparam logic [HeightRegW-1:0] HeightReset = 9'd240;
  localparam logic                  InvertReset = 1'b0;
  localparam logic                  TrackReset  = 1'b1;

  localparam logic [ByteW-1:0] ShadowFill = 8'hFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_INVERT = 3'd2,
    CFG_TRACK  = 3'd3
  } cfg_idx_t;

endpackage

FILE: src/mpdr_shadow.sv
// ----------------------------------------------------------------------------
// mpdr_shadow
// Shadow frame memory: one write port, one registered read port, and a
// clearing pass after reset that fills every entry with all ones.
// ----------------------------------------------------------------------------
module mpdr_shadow #(
  parameter int ADDR_W = 14,
  parameter int DEPTH  = 16384
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          rd_en,
  input  logic [ADDR_W-1:0]             rd_addr,
  output logic [mpdr_pkg::ByteW-1:0]    rd_data,
  input  logic                          wr_en,
  input  logic [ADDR_W-1:0]             wr_addr,
  input  logic [mpdr_pkg::ByteW-1:0]    wr_data,
  output logic                          clear_done
);

  logic [mpdr_pkg::ByteW-1:0] mem [DEPTH];
  logic [mpdr_pkg::ByteW-1:0] rd_data_r;
  logic                       clr_busy_r;
  logic [ADDR_W-1:0]          clr_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else if (clr_busy_r) begin
      if (clr_addr_r == ADDR_W'(DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_addr_r <= clr_addr_r + ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) begin
      mem[clr_addr_r] <= mpdr_pkg::ShadowFill;
    end else if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data    = rd_data_r;
  assign clear_done = !clr_busy_r;

endmodule

FILE: src/mono_pack_dirty_rows_top.sv
// ----------------------------------------------------------------------------
// mono_pack_dirty_rows_top
// RGB565 to 1 bit per pixel packer with shadow compare and dirty-row report.
// ----------------------------------------------------------------------------
// usage:
//   in_*   : one RGB565 pixel per transfer, raster order, nonzero is white.
//   out_*  : one transfer per completed byte (8 pixels or end of row), with
//            byte column and row; on the last byte of the frame frame_done is
//            set and the dirty report (any, first row, row count) is valid.
//   cfg_*  : register writes (width, height, invert, tracking), taken any
//            cycle, meant to be issued only while the block is idle.
// throughput: one pixel per cycle while the fill is done and out_ready is
//   high; the shadow ram has one read and one write port, and a byte
//   compared in the cycle after its read forwards its write to a following
//   read of the same entry. A byte-completing pixel goes through the compare
//   stage and then the result register.
// reset: config registers take their defaults, then the shadow ram of
//   MAX_HEIGHT * 2**ceil(log2(cols)) entries (16384 at the defaults) is
//   filled with all ones, one entry per cycle; in_ready is low meanwhile.
// stall: with out_ready low the result register holds, one more byte can wait
//   in the compare stage, and once both are full in_ready drops for every
//   pixel until the result is taken.
// ----------------------------------------------------------------------------
module mono_pack_dirty_rows_top #(
  parameter int MAX_WIDTH  = mpdr_pkg::MaxWidthDef,
  parameter int MAX_HEIGHT = mpdr_pkg::MaxHeightDef
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mpdr_pkg::PixelW-1:0]       in_pixel_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [mpdr_pkg::ByteW-1:0]        out_packed_byte,
  output logic [mpdr_pkg::ByteColW-1:0]     out_byte_column,
  output logic [mpdr_pkg::RowIdxW-1:0]      out_row_index,
  output logic                              out_frame_done,
  output logic                              out_any_dirty,
  output logic [mpdr_pkg::RowIdxW-1:0]      out_dirty_first_row,
  output logic [mpdr_pkg::CountW-1:0]       out_dirty_row_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mpdr_pkg::CfgIdxW-1:0]      cfg_index,
  input  logic [mpdr_pkg::CfgDataW-1:0]     cfg_data
);

  localparam int ColW        = $clog2(MAX_WIDTH);
  localparam int RowW        = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int HgtW        = $clog2(MAX_HEIGHT + 1);
  localparam int ShadowCols  = (MAX_WIDTH + 7) / 8;
  localparam int BcolW       = (ShadowCols > 1) ? $clog2(ShadowCols) : 1;
  localparam int AddrW       = RowW + BcolW;
  localparam int ShadowDepth = MAX_HEIGHT * (1 << BcolW);
  localparam int HeightRst   = int'(mpdr_pkg::HeightReset);
  localparam int FirstRst    = (HeightRst == 0) ? 1 :
                               ((HeightRst > MAX_HEIGHT) ? MAX_HEIGHT : HeightRst);
  localparam int BW          = mpdr_pkg::ByteW;

  // config registers
  logic [mpdr_pkg::WidthRegW-1:0]  cfg_width_r;
  logic [mpdr_pkg::HeightRegW-1:0] cfg_height_r;
  logic                            cfg_invert_r;
  logic                            cfg_track_r;

  // packer state
  logic [ColW-1:0]  col_r;
  logic [RowW-1:0]  row_r;
  logic [BW-1:0]    acc_r;
  logic             row_changed_r;
  logic [HgtW-1:0]  first_dirty_r;
  logic [HgtW-1:0]  end_dirty_r;

  // compare stage
  logic             s1_v_r;
  logic [BW-1:0]    s1_byte_r;
  logic [BcolW-1:0] s1_bcol_r;
  logic [RowW-1:0]  s1_row_r;
  logic             s1_row_end_r;
  logic             s1_frame_end_r;
  logic             s1_fwd_r;
  logic [BW-1:0]    s1_fwd_byte_r;

  // result register
  logic                          out_valid_r;
  logic [BW-1:0]                 out_byte_r;
  logic [mpdr_pkg::ByteColW-1:0] out_bcol_r;
  logic [mpdr_pkg::RowIdxW-1:0]  out_row_r;
  logic                          out_done_r;
  logic                          out_any_r;
  logic [mpdr_pkg::RowIdxW-1:0]  out_first_r;
  logic [mpdr_pkg::CountW-1:0]   out_count_r;

  logic [ColW-1:0]  w_m1;
  logic [RowW-1:0]  h_m1;
  logic [HgtW-1:0]  h_eff;
  logic             white;
  logic [BW-1:0]    acc_set;
  logic [BW-1:0]    in_byte;
  logic             row_end;
  logic             byte_end;
  logic             frame_end;
  logic [BcolW-1:0] in_bcol;
  logic             s1_go;
  logic             s1_adv;
  logic             in_xfer;
  logic             in_load;
  logic             clear_done;
  logic [AddrW-1:0] rd_addr;
  logic [AddrW-1:0] s1_addr;
  logic [BW-1:0]    rd_data;
  logic             wr_en;

  logic [BW-1:0]    old_byte;
  logic             changed;
  logic             rc;
  logic [HgtW-1:0]  first_upd;
  logic [HgtW-1:0]  end_upd;
  logic             any_rep;
  logic [HgtW-1:0]  first_rep;
  logic [HgtW-1:0]  count_rep;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_width_r  <= mpdr_pkg::WidthReset;
      cfg_height_r <= mpdr_pkg::HeightReset;
      cfg_invert_r <= mpdr_pkg::InvertReset;
      cfg_track_r  <= mpdr_pkg::TrackReset;
    end else if (cfg_valid) begin
      unique case (mpdr_pkg::cfg_idx_t'(cfg_index))
        mpdr_pkg::CFG_WIDTH: begin
          cfg_width_r <= cfg_data[mpdr_pkg::WidthRegW-1:0];
        end
        mpdr_pkg::CFG_HEIGHT: begin
          cfg_height_r <= cfg_data[mpdr_pkg::HeightRegW-1:0];
        end
        mpdr_pkg::CFG_INVERT: begin
          cfg_invert_r <= cfg_data[0];
        end
        mpdr_pkg::CFG_TRACK: begin
          cfg_track_r <= cfg_data[0];
        end
        default: begin
        end
      endcase
    end
  end

  // effective size, last column and last row
  always_comb begin
    priority if (cfg_width_r == '0) begin
      w_m1 = '0;
    end else if (32'(cfg_width_r) > MAX_WIDTH) begin
      w_m1 = ColW'(MAX_WIDTH - 1);
    end else begin
      w_m1 = ColW'(cfg_width_r - 10'd1);
    end
    priority if (cfg_height_r == '0) begin
      h_m1 = '0;
    end else if (32'(cfg_height_r) > MAX_HEIGHT) begin
      h_m1 = RowW'(MAX_HEIGHT - 1);
    end else begin
      h_m1 = RowW'(cfg_height_r - 9'd1);
    end
    h_eff = HgtW'(h_m1) + HgtW'(1);
  end

  // pixel intake
  assign white     = in_pixel_value != '0;
  assign acc_set   = acc_r | (BW'(white) << col_r[2:0]);
  assign in_byte   = acc_set ^ {BW{cfg_invert_r}};
  assign row_end   = col_r >= w_m1;
  assign byte_end  = row_end || (col_r[2:0] == 3'd7);
  assign frame_end = row_end && (row_r >= h_m1);
  assign in_bcol   = BcolW'(col_r >> 3);

  assign s1_go    = !out_valid_r || out_ready;
  assign s1_adv   = s1_v_r && s1_go;
  assign in_ready = clear_done && (!s1_v_r || s1_go);
  assign in_xfer  = in_valid && in_ready;
  assign in_load  = in_xfer && byte_end;

  assign rd_addr = {row_r, in_bcol};
  assign s1_addr = {s1_row_r, s1_bcol_r};
  assign wr_en   = s1_adv && cfg_track_r;

  mpdr_shadow #(
    .ADDR_W (AddrW),
    .DEPTH  (ShadowDepth)
  ) u_shadow (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (in_load),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data),
    .wr_en      (wr_en),
    .wr_addr    (s1_addr),
    .wr_data    (s1_byte_r),
    .clear_done (clear_done)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      acc_r <= '0;
    end else if (in_xfer) begin
      if (!byte_end) begin
        acc_r <= acc_set;
        col_r <= col_r + ColW'(1);
      end else begin
        acc_r <= '0;
        if (row_end) begin
          col_r <= '0;
          row_r <= frame_end ? '0 : row_r + RowW'(1);
        end else begin
          col_r <= col_r + ColW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_load) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      s1_byte_r      <= in_byte;
      s1_bcol_r      <= in_bcol;
      s1_row_r       <= row_r;
      s1_row_end_r   <= row_end;
      s1_frame_end_r <= frame_end;
      // entry written this cycle is not yet visible at the read port
      s1_fwd_r       <= wr_en && (rd_addr == s1_addr);
      s1_fwd_byte_r  <= s1_byte_r;
    end
  end

  // compare and dirty report
  always_comb begin
    old_byte  = s1_fwd_r ? s1_fwd_byte_r : rd_data;
    changed   = cfg_track_r && (old_byte != s1_byte_r);
    rc        = row_changed_r || changed;
    first_upd = first_dirty_r;
    end_upd   = end_dirty_r;
    if (s1_row_end_r && rc) begin
      if (HgtW'(s1_row_r) < first_dirty_r) begin
        first_upd = HgtW'(s1_row_r);
      end
      end_upd = HgtW'(s1_row_r) + HgtW'(1);
    end
    any_rep   = 1'b0;
    first_rep = '0;
    count_rep = '0;
    if (s1_frame_end_r) begin
      priority if (!cfg_track_r) begin
        any_rep   = 1'b1;
        count_rep = h_eff;
      end else if ((end_upd != '0) && (end_upd > first_upd)) begin
        any_rep   = 1'b1;
        first_rep = first_upd;
        count_rep = end_upd - first_upd;
      end else begin
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_changed_r <= 1'b0;
      first_dirty_r <= HgtW'(FirstRst);
      end_dirty_r   <= '0;
    end else if (s1_adv) begin
      row_changed_r <= s1_row_end_r ? 1'b0 : rc;
      first_dirty_r <= s1_frame_end_r ? h_eff : first_upd;
      end_dirty_r   <= s1_frame_end_r ? '0 : end_upd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r  <= s1_byte_r;
      out_bcol_r  <= mpdr_pkg::ByteColW'(s1_bcol_r);
      out_row_r   <= mpdr_pkg::RowIdxW'(s1_row_r);
      out_done_r  <= s1_frame_end_r;
      out_any_r   <= any_rep;
      out_first_r <= mpdr_pkg::RowIdxW'(first_rep);
      out_count_r <= mpdr_pkg::CountW'(count_rep);
    end
  end

  assign out_valid           = out_valid_r;
  assign out_packed_byte     = out_byte_r;
  assign out_byte_column     = out_bcol_r;
  assign out_row_index       = out_row_r;
  assign out_frame_done      = out_done_r;
  assign out_any_dirty       = out_any_r;
  assign out_dirty_first_row = out_first_r;
  assign out_dirty_row_count = out_count_r;

endmodule

FILE: src/mpdr_checker.sv
// ----------------------------------------------------------------------------
// mpdr_checker
// Port-level checks of the mono packer, bound to the top level.
// ----------------------------------------------------------------------------
module mpdr_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic                          out_frame_done,
  input logic                          out_any_dirty,
  input logic [mpdr_pkg::RowIdxW-1:0]  out_dirty_first_row,
  input logic [mpdr_pkg::CountW-1:0]   out_dirty_row_count
);

  // stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // report is zero away from the last byte
  a_report_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_done |->
      !out_any_dirty && (out_dirty_first_row == '0) && (out_dirty_row_count == '0))
    else $error("dirty report off the last byte");

  // clean frame reports nothing
  a_clean_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_any_dirty |->
      (out_dirty_first_row == '0) && (out_dirty_row_count == '0))
    else $error("clean frame with nonzero report");

  // nothing leaves and nothing is taken right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("activity right after reset");

endmodule

bind mono_pack_dirty_rows_top mpdr_checker u_mpdr_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_frame_done      (out_frame_done),
  .out_any_dirty       (out_any_dirty),
  .out_dirty_first_row (out_dirty_first_row),
  .out_dirty_row_count (out_dirty_row_count)
);
